[hdl/rwsm_pkg.sv]
// Shared types, register indexes, reset values and LCD segment tables for the
// reed wheel speed meter. No dependencies; every other file in hdl imports it.
package rwsm_pkg;

	localparam int CIRC_W     = 12;
	localparam int RATE_W     = 16;
	localparam int DEB_W      = 10;
	localparam int TMO_W      = 17;
	localparam int WIN_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 17;
	localparam int PASS_W     = 8;
	localparam int ACC_W      = 32;
	localparam int SPEED_W    = 16;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 32;
	localparam int NUM_W      = 40;
	localparam int DSH_W      = NUM_W + SPEED_W;
	localparam int BCD_W      = 20;
	localparam int CNT_W      = 5;

	localparam logic [CFG_IDX_W-1:0] REG_CIRCUMFERENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_RATE     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WINDOW        = 3'd4;

	localparam logic [CIRC_W-1:0] CIRC_RESET = 12'd2105;
	localparam logic [RATE_W-1:0] RATE_RESET = 16'd32764;
	localparam logic [DEB_W-1:0]  DEB_RESET  = 10'd16;
	localparam logic [TMO_W-1:0]  TMO_RESET  = 17'd65536;
	localparam logic [WIN_W-1:0]  WIN_RESET  = 17'd65536;

	localparam logic [SEG_W-1:0] SEG_POINT = 32'h0000_0020;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_SCALE,
		ST_DIV,
		ST_BCD,
		ST_DONE
	} rwsm_state_t;

	typedef struct packed {
		logic [CIRC_W-1:0] circumference_mm;
		logic [RATE_W-1:0] tick_rate_hz;
		logic [DEB_W-1:0]  debounce_ticks;
		logic [TMO_W-1:0]  interval_timeout_ticks;
		logic [WIN_W-1:0]  window_ticks;
	} rwsm_cfg_t;

	// Counts captured at the end of a window.
	typedef struct packed {
		logic              start;
		logic [PASS_W-1:0] passes;
		logic [ACC_W-1:0]  acc;
	} rwsm_snap_t;

	typedef struct packed {
		logic               valid;
		logic [SPEED_W-1:0] speed_tenths;
		logic [DIGIT_W-1:0] tens_digit;
		logic [DIGIT_W-1:0] units_digit;
		logic [DIGIT_W-1:0] tenths_digit;
		logic [SEG_W-1:0]   segment_word;
		logic [PASS_W-1:0]  passes;
	} rwsm_res_t;

	function automatic logic [SEG_W-1:0] seg_tens_f(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 32'h0001_0307;
			4'd1: s = 32'h0000_0104;
			4'd2: s = 32'h0800_0303;
			4'd3: s = 32'h0800_0306;
			4'd4: s = 32'h0801_0104;
			4'd5: s = 32'h0801_0206;
			4'd6: s = 32'h0801_0207;
			4'd7: s = 32'h0000_0304;
			4'd8: s = 32'h0801_0307;
			4'd9: s = 32'h0801_0306;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [SEG_W-1:0] seg_units_f(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 32'h06C2_0010;
			4'd1: s = 32'h0280_0000;
			4'd2: s = 32'h0640_0090;
			4'd3: s = 32'h06C0_0080;
			4'd4: s = 32'h0282_0080;
			4'd5: s = 32'h04C2_0080;
			4'd6: s = 32'h04C2_0090;
			4'd7: s = 32'h0680_0000;
			4'd8: s = 32'h06C2_0090;
			4'd9: s = 32'h06C2_0080;
			default: s = '0;
		endcase
		return s;
	endfunction

	function automatic logic [SEG_W-1:0] seg_tenths_f(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 32'h0000_EC40;
			4'd1: s = 32'h0000_2800;
			4'd2: s = 32'h0100_6440;
			4'd3: s = 32'h0100_6C00;
			4'd4: s = 32'h0100_A800;
			4'd5: s = 32'h0100_CC00;
			4'd6: s = 32'h0100_CC40;
			4'd7: s = 32'h0000_6800;
			4'd8: s = 32'h0100_EC40;
			4'd9: s = 32'h0100_EC00;
			default: s = '0;
		endcase
		return s;
	endfunction

endpackage

[hdl/rwsm_tick.sv]
// Per-tick counters: reed debounce, pass interval timer, tick accumulator,
// pass count and measurement window. Depends on rwsm_pkg.
module rwsm_tick (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rwsm_pkg::rwsm_cfg_t  cfg,
	input  logic                 tick,
	input  logic                 reed_level,
	output rwsm_pkg::rwsm_snap_t snap
);
	import rwsm_pkg::*;

	logic              last_q;
	logic              deb_busy_q;
	logic [DEB_W-1:0]  deb_cnt_q;
	logic              run_q;
	logic [TMO_W-1:0]  ivl_q;
	logic [ACC_W-1:0]  acc_q;
	logic [PASS_W-1:0] pass_q;
	logic [WIN_W-1:0]  win_q;

	logic              run_a;
	logic [TMO_W-1:0]  ivl_a;
	logic [TMO_W:0]    ivl_inc;
	logic [DEB_W:0]    deb_inc;
	logic              pass_ev;
	logic              busy_n;
	logic [DEB_W-1:0]  deb_cnt_n;
	logic [ACC_W:0]    acc_sum;
	logic              run_n;
	logic [TMO_W-1:0]  ivl_n;
	logic [ACC_W-1:0]  acc_n;
	logic [PASS_W-1:0] pass_n;
	logic [WIN_W:0]    win_inc;
	logic              win_end;

	always_comb begin
		// Interval timer runs first, so a pass in the same tick sees its new value.
		ivl_inc = {1'b0, ivl_q} + 1'b1;
		run_a = run_q;
		ivl_a = ivl_q;
		if (run_q) begin
			if (ivl_inc >= {1'b0, cfg.interval_timeout_ticks}) begin
				run_a = 1'b0;
				ivl_a = '0;
			end else begin
				ivl_a = ivl_inc[TMO_W-1:0];
			end
		end

		deb_inc = {1'b0, deb_cnt_q} + 1'b1;
		pass_ev = 1'b0;
		busy_n = deb_busy_q;
		deb_cnt_n = deb_cnt_q;
		if (last_q && !reed_level) begin
			busy_n = 1'b1;
			deb_cnt_n = '0;
		end else if (deb_busy_q) begin
			if (deb_inc >= {1'b0, cfg.debounce_ticks}) begin
				busy_n = 1'b0;
				deb_cnt_n = '0;
				pass_ev = !reed_level;
			end else begin
				deb_cnt_n = deb_inc[DEB_W-1:0];
			end
		end

		acc_sum = {1'b0, acc_q} + (ACC_W+1)'(ivl_a);
		run_n = run_a;
		ivl_n = ivl_a;
		acc_n = acc_q;
		pass_n = pass_q;
		if (pass_ev) begin
			if (run_a) begin
				acc_n = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
				if (pass_q != '1) begin
					pass_n = pass_q + 1'b1;
				end
				ivl_n = '0;
			end else begin
				run_n = 1'b1;
				ivl_n = '0;
			end
		end

		win_inc = {1'b0, win_q} + 1'b1;
		win_end = win_inc >= {1'b0, cfg.window_ticks};

		snap.start = tick && win_end;
		snap.passes = pass_n;
		snap.acc = acc_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b1;
			deb_busy_q <= 1'b0;
			deb_cnt_q <= '0;
			run_q <= 1'b0;
			ivl_q <= '0;
			acc_q <= '0;
			pass_q <= '0;
			win_q <= '0;
		end else if (tick) begin
			last_q <= reed_level;
			deb_busy_q <= busy_n;
			deb_cnt_q <= deb_cnt_n;
			run_q <= run_n;
			ivl_q <= ivl_n;
			if (win_end) begin
				acc_q <= '0;
				pass_q <= '0;
				win_q <= '0;
			end else begin
				acc_q <= acc_n;
				pass_q <= pass_n;
				win_q <= win_inc[WIN_W-1:0];
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) !run_q |-> ivl_q == '0)
		else $error("interval count not cleared while timer stopped");
	assert property (@(posedge clk) disable iff (!arst_n) !deb_busy_q |-> deb_cnt_q == '0)
		else $error("debounce count not cleared while idle");
	assert property (@(posedge clk) disable iff (!arst_n)
		snap.start |=> (pass_q == '0 && acc_q == '0))
		else $error("window counts not cleared after a report");

endmodule

[hdl/rwsm_speed.sv]
// Bit-serial speed unit: shift-add multiply, restoring divide one quotient bit
// per cycle, and shift-and-add-3 conversion to decimal digits. Depends on rwsm_pkg.
module rwsm_speed (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rwsm_pkg::rwsm_cfg_t  cfg,
	input  rwsm_pkg::rwsm_snap_t snap,
	input  logic                 take,
	output logic                 idle,
	output rwsm_pkg::rwsm_res_t  res
);
	import rwsm_pkg::*;

	rwsm_state_t state_q, state_n;

	logic [CNT_W-1:0]   cnt_q;
	logic [NUM_W-1:0]   a_q;
	logic [RATE_W-1:0]  b_q;
	logic [NUM_W-1:0]   p_q;
	logic [ACC_W-1:0]   acc_q;
	logic [PASS_W-1:0]  passes_q;
	logic [NUM_W-1:0]   rem_q;
	logic [DSH_W-1:0]   dsh_q;
	logic [SPEED_W-1:0] quo_q;
	logic [SPEED_W-1:0] bin_q;
	logic [BCD_W-1:0]   bcd_q;

	logic [NUM_W-1:0]   p_add;
	logic [NUM_W-1:0]   num;
	logic [NUM_W-1:0]   den;
	logic               div_ge;
	logic [DSH_W-1:0]   div_sub;
	logic [BCD_W-1:0]   bcd_adj;
	logic [BCD_W-1:0]   bcd_shift;
	logic               acc_zero;

	always_comb begin
		p_add = b_q[0] ? p_q + a_q : p_q;
		// Times 9 and times 250 as shifts and adds.
		num = {p_q[NUM_W-4:0], 3'b000} + p_q;
		den = {acc_q, 8'b0} - {6'b0, acc_q, 2'b0} - {7'b0, acc_q, 1'b0};
		div_ge = {{SPEED_W{1'b0}}, rem_q} >= dsh_q;
		div_sub = {{SPEED_W{1'b0}}, rem_q} - dsh_q;
		for (int i = 0; i < BCD_W / DIGIT_W; i++) begin
			bcd_adj[i*DIGIT_W +: DIGIT_W] = (bcd_q[i*DIGIT_W +: DIGIT_W] >= 4'd5) ?
				bcd_q[i*DIGIT_W +: DIGIT_W] + 4'd3 : bcd_q[i*DIGIT_W +: DIGIT_W];
		end
		bcd_shift = {bcd_adj[BCD_W-2:0], bin_q[SPEED_W-1]};
		acc_zero = acc_q == '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE:  if (snap.start) state_n = ST_MUL1;
			ST_MUL1:  if (cnt_q == '0) state_n = ST_MUL2;
			ST_MUL2:  if (cnt_q == '0) state_n = ST_SCALE;
			ST_SCALE: state_n = acc_zero ? ST_BCD : ST_DIV;
			ST_DIV: begin
				// A quotient bit above the result width means saturation.
				if ((cnt_q == CNT_W'(SPEED_W) && div_ge) || cnt_q == '0) begin
					state_n = ST_BCD;
				end
			end
			ST_BCD:   if (cnt_q == '0) state_n = ST_DONE;
			ST_DONE:  if (take) state_n = ST_IDLE;
			default:  state_n = ST_IDLE;
		endcase

		idle = state_q == ST_IDLE;
		res.valid = state_q == ST_DONE;
		res.speed_tenths = quo_q;
		res.tenths_digit = bcd_q[DIGIT_W-1:0];
		res.units_digit = bcd_q[2*DIGIT_W-1:DIGIT_W];
		res.tens_digit = bcd_q[3*DIGIT_W-1:2*DIGIT_W];
		res.segment_word = seg_tens_f(res.tens_digit) | seg_units_f(res.units_digit)
			| seg_tenths_f(res.tenths_digit) | SEG_POINT;
		res.passes = passes_q;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (snap.start) begin
					a_q <= NUM_W'(cfg.circumference_mm);
					b_q <= RATE_W'(snap.passes);
					p_q <= '0;
					cnt_q <= CNT_W'(PASS_W - 1);
					acc_q <= snap.acc;
					passes_q <= snap.passes;
				end
			end
			ST_MUL1: begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					a_q <= p_add;
					b_q <= cfg.tick_rate_hz;
					p_q <= '0;
					cnt_q <= CNT_W'(RATE_W - 1);
				end else begin
					p_q <= p_add;
					a_q <= {a_q[NUM_W-2:0], 1'b0};
					b_q <= {1'b0, b_q[RATE_W-1:1]};
				end
			end
			ST_MUL2: begin
				p_q <= p_add;
				a_q <= {a_q[NUM_W-2:0], 1'b0};
				b_q <= {1'b0, b_q[RATE_W-1:1]};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_SCALE: begin
				rem_q <= num;
				dsh_q <= {den, {SPEED_W{1'b0}}};
				quo_q <= '0;
				bin_q <= '0;
				bcd_q <= '0;
				cnt_q <= acc_zero ? CNT_W'(SPEED_W - 1) : CNT_W'(SPEED_W);
			end
			ST_DIV: begin
				dsh_q <= {1'b0, dsh_q[DSH_W-1:1]};
				if (cnt_q == CNT_W'(SPEED_W)) begin
					cnt_q <= CNT_W'(SPEED_W - 1);
					if (div_ge) begin
						quo_q <= '1;
						bin_q <= '1;
						bcd_q <= '0;
					end
				end else begin
					if (div_ge) begin
						rem_q <= div_sub[NUM_W-1:0];
					end
					quo_q <= {quo_q[SPEED_W-2:0], div_ge};
					if (cnt_q == '0) begin
						bin_q <= {quo_q[SPEED_W-2:0], div_ge};
						bcd_q <= '0;
						cnt_q <= CNT_W'(SPEED_W - 1);
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
			end
			ST_BCD: begin
				bcd_q <= bcd_shift;
				bin_q <= {bin_q[SPEED_W-2:0], 1'b0};
				cnt_q <= cnt_q - 1'b1;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n) snap.start |-> state_q == ST_IDLE)
		else $error("window snapshot arrived while speed unit busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q <= CNT_W'(SPEED_W))
		else $error("divide step count out of range");
	assert property (@(posedge clk) disable iff (!arst_n) state_q == ST_DONE |->
		(bcd_q[3:0] <= 4'd9 && bcd_q[7:4] <= 4'd9 && bcd_q[11:8] <= 4'd9))
		else $error("decimal digit out of range");

endmodule

[hdl/reed_wheel_speed_meter.sv]
// Top level of the reed wheel speed meter: configuration registers, output
// register and handshakes. Depends on rwsm_pkg, rwsm_tick and rwsm_speed.
//
//  Channel   Handshake              Payload
//  --------  ---------------------  ------------------------------------------
//  in        in_valid / in_ready    reed_level (one timebase tick)
//  out       out_valid / out_ready  speed_tenths, digits, segment_word, passes
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A tick that does not close a window is accepted while in_ready stays high.
// A tick that closes a window starts the serial speed calculation: multiply by
// pass count, multiply by tick rate, scale, divide steps (skipped when the
// interval sum is zero) and digit steps, during which in_ready is low.
// The result waits in the output register; if it is still full when the next
// result is ready, the speed unit holds that result until the register frees.
// Reset restores the default configuration and clears all counts; cfg_ready is
// always high.
module reed_wheel_speed_meter (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic                                 reed_level,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [rwsm_pkg::SPEED_W-1:0]         speed_tenths,
	output logic [rwsm_pkg::DIGIT_W-1:0]         tens_digit,
	output logic [rwsm_pkg::DIGIT_W-1:0]         units_digit,
	output logic [rwsm_pkg::DIGIT_W-1:0]         tenths_digit,
	output logic [rwsm_pkg::SEG_W-1:0]           segment_word,
	output logic [rwsm_pkg::PASS_W-1:0]          passes_in_window,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rwsm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rwsm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rwsm_pkg::*;

	rwsm_cfg_t  cfg_q;
	rwsm_snap_t snap;
	rwsm_res_t  res;
	logic       idle;
	logic       tick;
	logic       take;
	logic       out_valid_q;

	assign cfg_ready = 1'b1;
	assign in_ready = idle;
	assign tick = in_valid && in_ready;
	assign take = res.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.circumference_mm <= CIRC_RESET;
			cfg_q.tick_rate_hz <= RATE_RESET;
			cfg_q.debounce_ticks <= DEB_RESET;
			cfg_q.interval_timeout_ticks <= TMO_RESET;
			cfg_q.window_ticks <= WIN_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CIRCUMFERENCE: cfg_q.circumference_mm <= cfg_data[CIRC_W-1:0];
				REG_TICK_RATE:     cfg_q.tick_rate_hz <= cfg_data[RATE_W-1:0];
				REG_DEBOUNCE:      cfg_q.debounce_ticks <= cfg_data[DEB_W-1:0];
				REG_TIMEOUT:       cfg_q.interval_timeout_ticks <= cfg_data[TMO_W-1:0];
				REG_WINDOW:        cfg_q.window_ticks <= cfg_data[WIN_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			speed_tenths <= res.speed_tenths;
			tens_digit <= res.tens_digit;
			units_digit <= res.units_digit;
			tenths_digit <= res.tenths_digit;
			segment_word <= res.segment_word;
			passes_in_window <= res.passes;
		end
	end

	rwsm_tick u_tick (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.tick       (tick),
		.reed_level (reed_level),
		.snap       (snap)
	);

	rwsm_speed u_speed (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.snap   (snap),
		.take   (take),
		.idle   (idle),
		.res    (res)
	);

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for reed_wheel_speed_meter: reed waveforms with random
// handshake gaps, checked report by report against a tick-level model of the meter.
// Depends on rwsm_pkg and the RTL in hdl.
module testbench;
	import rwsm_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic [SPEED_W-1:0] speed_tenths;
		logic [DIGIT_W-1:0] tens_digit;
		logic [DIGIT_W-1:0] units_digit;
		logic [DIGIT_W-1:0] tenths_digit;
		logic [SEG_W-1:0]   segment_word;
		logic [PASS_W-1:0]  passes;
	} speed_report_t;

	// Tick-level model of the meter and the queue of reports it has produced.
	class wheel_tracker;
		rwsm_cfg_t         setup;
		bit                last_level;
		bit                deb_busy;
		logic [DEB_W-1:0]  deb_count;
		bit                ival_running;
		logic [TMO_W-1:0]  ival_count;
		logic [ACC_W-1:0]  acc;
		logic [PASS_W-1:0] passes;
		logic [WIN_W-1:0]  win_count;
		speed_report_t     pending_reports[$];
		int                mismatches;

		function new();
			setup.circumference_mm = CIRC_RESET;
			setup.tick_rate_hz = RATE_RESET;
			setup.debounce_ticks = DEB_RESET;
			setup.interval_timeout_ticks = TMO_RESET;
			setup.window_ticks = WIN_RESET;
			last_level = 1'b1;
			deb_busy = 1'b0;
			deb_count = '0;
			ival_running = 1'b0;
			ival_count = '0;
			acc = '0;
			passes = '0;
			win_count = '0;
			mismatches = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_CIRCUMFERENCE: setup.circumference_mm = data[CIRC_W-1:0];
				REG_TICK_RATE:     setup.tick_rate_hz = data[RATE_W-1:0];
				REG_DEBOUNCE:      setup.debounce_ticks = data[DEB_W-1:0];
				REG_TIMEOUT:       setup.interval_timeout_ticks = data[TMO_W-1:0];
				REG_WINDOW:        setup.window_ticks = data[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		function void tick(bit level);
			logic [SEG_W-1:0] tens_seg [10] = '{
				32'h0001_0307, 32'h0000_0104, 32'h0800_0303, 32'h0800_0306, 32'h0801_0104,
				32'h0801_0206, 32'h0801_0207, 32'h0000_0304, 32'h0801_0307, 32'h0801_0306};
			logic [SEG_W-1:0] units_seg [10] = '{
				32'h06C2_0010, 32'h0280_0000, 32'h0640_0090, 32'h06C0_0080, 32'h0282_0080,
				32'h04C2_0080, 32'h04C2_0090, 32'h0680_0000, 32'h06C2_0090, 32'h06C2_0080};
			logic [SEG_W-1:0] tenths_seg [10] = '{
				32'h0000_EC40, 32'h0000_2800, 32'h0100_6440, 32'h0100_6C00, 32'h0100_A800,
				32'h0100_CC00, 32'h0100_CC40, 32'h0000_6800, 32'h0100_EC40, 32'h0100_EC00};
			logic [ACC_W:0]     sum;
			logic [63:0]        num;
			logic [63:0]        den;
			logic [63:0]        quot;
			logic [SPEED_W-1:0] spd;
			speed_report_t      rep;

			if (ival_running) begin
				ival_count++;
				if (ival_count >= setup.interval_timeout_ticks) begin
					ival_running = 1'b0;
					ival_count = '0;
				end
			end

			if (last_level && !level) begin
				deb_busy = 1'b1;
				deb_count = '0;
			end else if (deb_busy) begin
				deb_count++;
				if (deb_count >= setup.debounce_ticks) begin
					deb_busy = 1'b0;
					deb_count = '0;
					if (!level) begin
						// The first pass only starts the timer; later ones close an interval.
						if (ival_running) begin
							sum = {1'b0, acc} + (ACC_W+1)'(ival_count);
							acc = sum[ACC_W] ? '1 : sum[ACC_W-1:0];
							if (passes != '1)
								passes++;
						end
						ival_running = 1'b1;
						ival_count = '0;
					end
				end
			end

			win_count++;
			if (win_count >= setup.window_ticks) begin
				win_count = '0;
				if (acc == '0) begin
					spd = '0;
				end else begin
					num = 64'(passes) * 64'(setup.circumference_mm) * 64'(setup.tick_rate_hz) * 64'd9;
					den = 64'(acc) * 64'd250;
					quot = num / den;
					spd = (quot > 64'd65535) ? '1 : quot[SPEED_W-1:0];
				end
				rep.speed_tenths = spd;
				rep.tens_digit = DIGIT_W'((spd / 100) % 10);
				rep.units_digit = DIGIT_W'((spd / 10) % 10);
				rep.tenths_digit = DIGIT_W'(spd % 10);
				rep.segment_word = tens_seg[rep.tens_digit] | units_seg[rep.units_digit]
					| tenths_seg[rep.tenths_digit] | SEG_POINT;
				rep.passes = passes;
				pending_reports.push_back(rep);
				passes = '0;
				acc = '0;
			end

			last_level = level;
		endfunction

		function void field_check(string name, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				mismatches++;
			end
		endfunction

		function void report_check(speed_report_t got);
			speed_report_t want;
			if (pending_reports.size() == 0) begin
				$error("report arrived with none outstanding: speed_tenths %0d", got.speed_tenths);
				mismatches++;
			end else begin
				want = pending_reports.pop_front();
				field_check("speed_tenths", want.speed_tenths, got.speed_tenths);
				field_check("tens_digit", want.tens_digit, got.tens_digit);
				field_check("units_digit", want.units_digit, got.units_digit);
				field_check("tenths_digit", want.tenths_digit, got.tenths_digit);
				field_check("segment_word", want.segment_word, got.segment_word);
				field_check("passes_in_window", want.passes, got.passes);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  reed_level = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [SPEED_W-1:0]    speed_tenths;
	logic [DIGIT_W-1:0]    tens_digit;
	logic [DIGIT_W-1:0]    units_digit;
	logic [DIGIT_W-1:0]    tenths_digit;
	logic [SEG_W-1:0]      segment_word;
	logic [PASS_W-1:0]     passes_in_window;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	wheel_tracker track;
	bit           reed_plan[$];
	int           quiet_cycles = 0;
	int           burst_left = 0;
	int           rx_left = 0;
	bit           rx_on = 1'b0;

	reed_wheel_speed_meter i_dut (.*);

	always #5 clk = ~clk;

	// Every accepted transaction is handed to the model at the edge that accepts it.
	always @(posedge clk) begin
		speed_report_t got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				got.speed_tenths = speed_tenths;
				got.tens_digit = tens_digit;
				got.units_digit = units_digit;
				got.tenths_digit = tenths_digit;
				got.segment_word = segment_word;
				got.passes = passes_in_window;
				track.report_check(got);
			end
			if (in_valid && in_ready)
				track.tick(reed_level);
			if (cfg_valid && cfg_ready)
				track.set_reg(cfg_index, cfg_data);
		end
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("testbench: errors");
		$finish;
	end

	// Receiver back-pressure: runs of ready and stall, with occasional long open stretches.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			case ($urandom_range(0, 5))
				0: begin
					rx_on = 1'b1;
					rx_left = $urandom_range(60, 200);
				end
				1, 2: begin
					rx_on = 1'b0;
					rx_left = $urandom_range(1, 12);
				end
				default: begin
					rx_on = 1'b1;
					rx_left = $urandom_range(1, 15);
				end
			endcase
		end else begin
			rx_left--;
		end
		out_ready <= rx_on;
	end

	task automatic send_level(input bit level);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		reed_level <= level;
		burst_left--;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Registers change only once every report is out and the speed unit has gone quiet.
	task automatic configure(input int circ, input int rate, input int deb, input int tmo,
		input int win);
		@(negedge clk);
		in_valid <= 1'b0;
		while (track.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_CIRCUMFERENCE, CFG_DATA_W'(circ));
		write_reg(REG_TICK_RATE, CFG_DATA_W'(rate));
		write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb));
		write_reg(REG_TIMEOUT, CFG_DATA_W'(tmo));
		write_reg(REG_WINDOW, CFG_DATA_W'(win));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Wheel revolutions: high stretch, optional contact bounce, low stretch around the
	// debounce time. A clean plan gives the fastest wheel the debounce allows.
	task automatic plan_wheel(input int count, input int deb, input int hi_max, input bit clean);
		int pick;
		int lo;
		while (reed_plan.size() < count) begin
			pick = $urandom_range(0, 99);
			if (!clean && pick < 12) begin
				repeat ($urandom_range(1, 8)) reed_plan.push_back(1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(1, hi_max)) reed_plan.push_back(1'b1);
				if (!clean && pick < 35) begin
					repeat ($urandom_range(1, 3)) begin
						reed_plan.push_back(1'b0);
						reed_plan.push_back(1'b1);
					end
				end
				if (clean)
					lo = deb + 2;
				else if ($urandom_range(0, 3) != 0)
					lo = deb + $urandom_range(2, 6);
				else
					lo = $urandom_range(1, deb + 1);
				if (lo > 48)
					lo = $urandom_range(1, 48);
				repeat (lo) reed_plan.push_back(1'b0);
			end
		end
		while (reed_plan.size() != 0)
			send_level(reed_plan.pop_front());
	endtask

	initial begin
		bit [0:11] fast_wheel;
		bit [0:9]  bouncy;
		int circ;
		int rate;
		int deb;
		int tmo;
		int win;
		int count;
		bit clean;

		fast_wheel = 12'b1001_0010_1000;
		bouncy = 10'b0100_1000_11;
		track = new();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// Saturated speed with a zero debounce, and a sample that finds the switch open.
		configure(4095, 65535, 0, 131071, 12);
		foreach (fast_wheel[i]) send_level(fast_wheel[i]);

		// Report on every tick, timer stopping every tick, zero rate, restarted debounce.
		configure(1, 0, 3, 0, 0);
		foreach (bouncy[i]) send_level(bouncy[i]);

		for (int k = 0; k < 11; k++) begin
			case ($urandom_range(0, 4))
				0: circ = 0;
				1: circ = 1;
				2: circ = 4095;
				default: circ = $urandom_range(300, 3000);
			endcase
			case ($urandom_range(0, 4))
				0: rate = 0;
				1: rate = 1;
				2: rate = 65535;
				default: rate = $urandom_range(1000, 40000);
			endcase
			case ($urandom_range(0, 9))
				0: deb = 1023;
				1: deb = $urandom_range(7, 30);
				default: deb = $urandom_range(0, 6);
			endcase
			case ($urandom_range(0, 5))
				0: tmo = 0;
				1: tmo = 1;
				2: tmo = 131071;
				default: tmo = $urandom_range(8, 400);
			endcase
			win = $urandom_range(16, 160);
			count = 80;
			clean = 1'b0;
			case (k)
				3: begin
					win = 0;
					count = 60;
				end
				6: begin
					// Long window with a fast wheel drives the pass count into saturation,
					// even when the window is already part way through at the start.
					deb = 0;
					tmo = 131071;
					win = 960;
					count = 980;
					clean = 1'b1;
				end
				9: win = 131071;
				default: ;
			endcase
			configure(circ, rate, deb, tmo, win);
			plan_wheel(count, deb, clean ? 1 : 20, clean);
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (track.pending_reports.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (track.mismatches == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
